// ===== design/srf_pkg.sv =====
// ----------------------------------------------------------------------------
// srf_pkg
// Shared types, constants and helpers for the first-occurrence substring
// replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package srf_pkg;

    localparam int MAX_SOURCE  = 48;
    localparam int MAX_PATTERN = 16;
    localparam int REPL_MAX    = 16;

    localparam int ADDR_W = $clog2(MAX_SOURCE);
    localparam int LEN_W  = 5;
    localparam int IDX_W  = 4;

    typedef enum logic [2:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_PATTERN_LEN  = 3'd2,
        REG_REPL_LOW     = 3'd3,
        REG_REPL_HIGH    = 3'd4,
        REG_REPL_LEN     = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    // configuration as seen by the datapath, lengths already saturated
    typedef struct packed {
        logic [127:0]     pattern;
        logic [LEN_W-1:0] pattern_len;
        logic [127:0]     repl;
        logic [LEN_W-1:0] repl_len;
    } cfg_t;

    function automatic logic [7:0] byte_sel(input logic [127:0] w,
                                            input logic [IDX_W-1:0] idx);
        byte_sel = w[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== design/srf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// srf_cfg_regs
// Configuration register file: pattern and replacement strings and their
// lengths, with lengths clamped to the supported maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module srf_cfg_regs
    import srf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output cfg_t             cfg
);

    logic [63:0]      pat_lo_reg;
    logic [63:0]      pat_hi_reg;
    logic [LEN_W-1:0] pat_len_reg;
    logic [63:0]      rep_lo_reg;
    logic [63:0]      rep_hi_reg;
    logic [LEN_W-1:0] rep_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= '0;
            rep_lo_reg  <= '0;
            rep_hi_reg  <= '0;
            rep_len_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:  pat_lo_reg  <= cfg_data;
                REG_PATTERN_HIGH: pat_hi_reg  <= cfg_data;
                REG_PATTERN_LEN:  pat_len_reg <= cfg_data[LEN_W-1:0];
                REG_REPL_LOW:     rep_lo_reg  <= cfg_data;
                REG_REPL_HIGH:    rep_hi_reg  <= cfg_data;
                REG_REPL_LEN:     rep_len_reg <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.pattern     = {pat_hi_reg, pat_lo_reg};
        cfg.repl        = {rep_hi_reg, rep_lo_reg};
        cfg.pattern_len = (pat_len_reg > LEN_W'(MAX_PATTERN)) ?
                          LEN_W'(MAX_PATTERN) : pat_len_reg;
        cfg.repl_len    = (rep_len_reg > LEN_W'(REPL_MAX)) ?
                          LEN_W'(REPL_MAX) : rep_len_reg;
    end

endmodule

`default_nettype wire

// ===== design/substring_replace_first_core.sv =====
// Sequence: one source byte is accepted per cycle in the load state; after
//   the last byte a check state, then a naive search with one buffer read
//   and one compare per pattern byte compared, then a read and a write per
//   result byte. One string at a time; in_stall is high outside loading.
// Reset: control, lengths and configuration clear; the source buffer is not
//   cleared, it is always written before it is read.
// ----------------------------------------------------------------------------
// substring_replace_first_core
// Buffers a source string, finds the leftmost pattern occurrence and streams
// out the string with that occurrence replaced (unchanged if none is found).
// ----------------------------------------------------------------------------
`default_nettype none

module substring_replace_first_core
    import srf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // source channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        has_byte,
    input  wire logic        last,
    // result channel
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [7:0]       out_byte,
    output logic             out_valid,
    output logic             out_last,
    output logic             found,
    output logic [5:0]       match_position,
    output logic             truncated,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    cfg_t cfg;

    srf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // source buffer
    logic [7:0]        mem [MAX_SOURCE];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= in_byte;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0] rn_reg, rn_next;
    logic              sel_repl_reg, sel_repl_next;
    logic [7:0]        repl_byte_reg, repl_byte_next;

    logic              res_valid_reg, res_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;
    logic              found_o_reg, found_o_next;
    logic [5:0]        pos_o_reg, pos_o_next;
    logic              trunc_o_reg, trunc_o_next;

    // 7-bit helpers for length arithmetic
    logic [ADDR_W:0] len7, plen7, rlen7, k7, pos7, i7;
    logic [ADDR_W:0] rn_found7, pos_end7, tail_addr7;
    logic            k_is_last;

    always_comb
    begin
        len7       = {1'b0, len_reg};
        plen7      = (ADDR_W+1)'(cfg.pattern_len);
        rlen7      = (ADDR_W+1)'(cfg.repl_len);
        k7         = {1'b0, k_reg};
        pos7       = {1'b0, pos_reg};
        i7         = {1'b0, i_reg};
        rn_found7  = len7 - plen7 + rlen7;
        pos_end7   = pos7 + rlen7;
        tail_addr7 = k7 - rlen7 + plen7;
        k_is_last  = (rn_reg == '0) || ((k7 + 1'b1) == {1'b0, rn_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
            k_reg         <= '0;
            rn_reg        <= '0;
            sel_repl_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            found_reg     <= found_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            rn_reg        <= rn_next;
            sel_repl_reg  <= sel_repl_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        repl_byte_reg <= repl_byte_next;
        out_byte_reg  <= out_byte_next;
        out_valid_reg <= out_valid_next;
        out_last_reg  <= out_last_next;
        found_o_reg   <= found_o_next;
        pos_o_reg     <= pos_o_next;
        trunc_o_reg   <= trunc_o_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        rn_next        = rn_reg;
        sel_repl_next  = sel_repl_reg;
        repl_byte_next = repl_byte_reg;
        res_valid_next = res_valid_reg && res_stall;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        found_o_next   = found_o_reg;
        pos_o_next     = pos_o_reg;
        trunc_o_next   = trunc_o_reg;
        mem_we         = 1'b0;
        mem_waddr      = len_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        in_stall       = (state_reg != ST_LOAD);

        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (has_byte)
                    begin
                        if (len_reg < ADDR_W'(MAX_SOURCE))
                        begin
                            mem_we   = 1'b1;
                            len_next = len_reg + 1'b1;
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    if (last)
                        state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                i_next     = '0;
                j_next     = '0;
                k_next     = '0;
                found_next = 1'b0;
                pos_next   = '0;
                rn_next    = len_reg;
                if (cfg.pattern_len != '0 && plen7 <= len7)
                    state_next = ST_SRCH_RD;
                else
                    state_next = ST_EMIT_RD;
            end

            ST_SRCH_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = i_reg + ADDR_W'(j_reg);
                state_next = ST_SRCH_CMP;
            end

            ST_SRCH_CMP:
            begin
                if (rd_data_reg == byte_sel(cfg.pattern, j_reg))
                begin
                    if (({1'b0, j_reg} + 1'b1) == cfg.pattern_len)
                    begin
                        found_next = 1'b1;
                        pos_next   = i_reg;
                        rn_next    = rn_found7[ADDR_W-1:0];
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_SRCH_RD;
                    end
                end
                else if ((i7 + 1'b1 + plen7) > len7)
                    state_next = ST_EMIT_RD;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    j_next     = '0;
                    state_next = ST_SRCH_RD;
                end
            end

            ST_EMIT_RD:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    sel_repl_next  = found_reg && (k7 >= pos7) && (k7 < pos_end7);
                    repl_byte_next = byte_sel(cfg.repl, IDX_W'(k7 - pos7));
                    if (found_reg && (k7 >= pos_end7))
                        mem_raddr = tail_addr7[ADDR_W-1:0];
                    else
                        mem_raddr = k_reg;
                    mem_re     = (rn_reg != '0) && !sel_repl_next;
                    state_next = ST_EMIT_WR;
                end
            end

            ST_EMIT_WR:
            begin
                // output register was drained in the read cycle
                res_valid_next = 1'b1;
                out_valid_next = (rn_reg != '0);
                if (rn_reg == '0)
                    out_byte_next = '0;
                else if (sel_repl_reg)
                    out_byte_next = repl_byte_reg;
                else
                    out_byte_next = rd_data_reg;
                out_last_next = k_is_last;
                found_o_next  = found_reg;
                pos_o_next    = pos_reg;
                trunc_o_next  = ovf_reg;
                if (k_is_last)
                begin
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_EMIT_RD;
                end
            end

            default:
                state_next = ST_LOAD;
        endcase
    end

    assign res_valid      = res_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_valid      = out_valid_reg;
    assign out_last       = out_last_reg;
    assign found          = found_o_reg;
    assign match_position = pos_o_reg;
    assign truncated      = trunc_o_reg;

endmodule

`default_nettype wire
